>>> hw/rtl/plm_pkg.sv
// Package for the polyline length projection block.
// Holds the sequencer state type, register indexes and shared widths.
// No dependencies.
package plm_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PT_AW      = 6;
  localparam int DIV_NW     = 64;
  localparam int DIV_DW     = 40;

  localparam logic [1:0] CFG_RANGE_MIN = 2'd0;
  localparam logic [1:0] CFG_RANGE_MAX = 2'd1;
  localparam logic [1:0] CFG_WEIGHT    = 2'd2;

  localparam logic [63:0] EDGE_SAT = 64'h0000_7FFF_FFFF_FFFF;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SQ,
    ST_SQRT,
    ST_DECIDE,
    ST_E_RD,
    ST_E_AX,
    ST_E_DIV0,
    ST_E_DIV,
    ST_E_WR,
    ST_O_RD,
    ST_O_T,
    ST_O_DIV0,
    ST_O_DIV,
    ST_O_ML,
    ST_O_MH,
    ST_O_SAT,
    ST_O_SEND
  } state_t;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] m;
    m = v[32] ? -v : v;
    return m[31:0];
  endfunction

endpackage

>>> hw/rtl/plm_div.sv
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// Uses plm_pkg for its widths.
module plm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [plm_pkg::DIV_NW-1:0]  dividend,
  input  logic [plm_pkg::DIV_DW-1:0]  divisor,
  output logic                        done,
  output logic [plm_pkg::DIV_NW-1:0]  quotient
);

  logic                        busy_r;
  logic                        done_r;
  logic [5:0]                  cnt_r;
  logic [plm_pkg::DIV_DW-1:0]  rem_r;
  logic [plm_pkg::DIV_DW-1:0]  dvs_r;
  logic [plm_pkg::DIV_NW-1:0]  quo_r;
  logic [plm_pkg::DIV_DW:0]    shifted;
  logic [plm_pkg::DIV_DW:0]    diff;
  logic                        ge;

  assign shifted = {rem_r, quo_r[plm_pkg::DIV_NW-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[plm_pkg::DIV_DW-1:0] : shifted[plm_pkg::DIV_DW-1:0];
      quo_r <= {quo_r[plm_pkg::DIV_NW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hw/rtl/polyline_length_projection_unit.sv
// Sequence: each stored point word after the first holds the input off while the squares
// are summed and the square root is taken. After the last word come a decision state, the
// edge pass (a scaled edge divides each axis in the shared 64-step divider) and, for each
// result word, a divide, two multiplies and saturation per axis before the word is offered.
// Input stays stalled until the last result word leaves. Reset (synchronous, rst_n low) clears
// the point count and length sum and restores register defaults; memories are not cleared.
module polyline_length_projection_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // point_x, point_y, point_z
  input  logic         in_tlast,   // last_point
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // proj_x, proj_y, proj_z, point_index, zero fill
  output logic         out_tlast,  // last_result
  output logic         out_tuser,  // degenerate
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  plm_pkg::state_t state_r, state_nxt;

  logic [31:0] range_min_r, range_max_r, weight_r;

  logic [6:0]  count_r, count_nxt;
  logic [39:0] len_r, len_nxt;
  logic        last_r, last_nxt;
  logic signed [31:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt, prev_z_r, prev_z_nxt;
  logic signed [32:0] dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic [67:0] rad_r, rad_nxt;
  logic [33:0] root_r, root_nxt;
  logic [35:0] srem_r, srem_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [1:0]  axis_r, axis_nxt;
  logic [6:0]  k_r, k_nxt;
  logic        scale_r, scale_nxt, degen_r, degen_nxt;
  logic [31:0] num_r, num_nxt;
  logic signed [63:0] pos_r [3];
  logic signed [63:0] pos_nxt [3];
  logic signed [63:0] sum_r [3];
  logic signed [63:0] sum_nxt [3];
  logic signed [63:0] t_r, t_nxt;
  logic [63:0] q_r, q_nxt, wlo_r, wlo_nxt;
  logic [31:0] res_r [3];
  logic [31:0] res_nxt [3];

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p_r;

  logic [98:0]  dmem [plm_pkg::MAX_POINTS];
  logic [98:0]  dmem_q_r;
  logic         dm_we;
  logic [98:0]  dm_wdata;
  logic [191:0] pmem [plm_pkg::MAX_POINTS];
  logic [191:0] pmem_q_r;
  logic         pm_we;
  logic [191:0] pm_wdata;

  logic        div_start, div_done;
  logic [63:0] div_dividend, div_quo;
  logic [39:0] div_divisor;

  logic signed [32:0] in_dx, in_dy, in_dz, d_sel;
  logic signed [63:0] pos_sel, e_val, np;
  logic [37:0] sq_cur, sq_trial;
  logic [63:0] q_sat;
  logic [95:0] full;
  logic        big;

  plm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= 32'h0000_0000;
      range_max_r <= 32'hFFFF_FFFF;
      weight_r    <= 32'h0001_0000;
    end else if (cfg_valid) begin
      case (cfg_index)
        plm_pkg::CFG_RANGE_MIN: range_min_r <= cfg_data;
        plm_pkg::CFG_RANGE_MAX: range_max_r <= cfg_data;
        plm_pkg::CFG_WEIGHT:    weight_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_p_r  <= mul_a * mul_b;
    dmem_q_r <= dmem[k_r[plm_pkg::PT_AW-1:0]];
    pmem_q_r <= pmem[k_r[plm_pkg::PT_AW-1:0]];
    if (dm_we) begin
      dmem[count_r[plm_pkg::PT_AW-1:0]] <= dm_wdata;
    end
    if (pm_we) begin
      pmem[k_r[plm_pkg::PT_AW-1:0]] <= pm_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plm_pkg::ST_LOAD;
      count_r <= '0;
      len_r   <= '0;
      k_r     <= '0;
      axis_r  <= '0;
      step_r  <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      len_r   <= len_nxt;
      k_r     <= k_nxt;
      axis_r  <= axis_nxt;
      step_r  <= step_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_x_r <= prev_x_nxt;
    prev_y_r <= prev_y_nxt;
    prev_z_r <= prev_z_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    dz_r     <= dz_nxt;
    rad_r    <= rad_nxt;
    root_r   <= root_nxt;
    srem_r   <= srem_nxt;
    scale_r  <= scale_nxt;
    degen_r  <= degen_nxt;
    num_r    <= num_nxt;
    t_r      <= t_nxt;
    q_r      <= q_nxt;
    wlo_r    <= wlo_nxt;
    for (int i = 0; i < 3; i++) begin
      pos_r[i] <= pos_nxt[i];
      sum_r[i] <= sum_nxt[i];
      res_r[i] <= res_nxt[i];
    end
  end

  assign in_dx = {in_tdata[31], in_tdata[31:0]} - {prev_x_r[31], prev_x_r};
  assign in_dy = {in_tdata[63], in_tdata[63:32]} - {prev_y_r[31], prev_y_r};
  assign in_dz = {in_tdata[95], in_tdata[95:64]} - {prev_z_r[31], prev_z_r};

  always_comb begin
    case (axis_r)
      2'd0:    d_sel = dmem_q_r[32:0];
      2'd1:    d_sel = dmem_q_r[65:33];
      default: d_sel = dmem_q_r[98:66];
    endcase
    case (axis_r)
      2'd0:    pos_sel = pmem_q_r[63:0];
      2'd1:    pos_sel = pmem_q_r[127:64];
      default: pos_sel = pmem_q_r[191:128];
    endcase
  end

  assign sq_cur   = {srem_r, rad_r[67:66]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign q_sat    = (div_quo[63:47] != '0) ? plm_pkg::EDGE_SAT : div_quo;
  assign np       = pos_sel * $signed({1'b0, count_r});
  assign full     = {mul_p_r, 32'h0} + {32'h0, wlo_r};
  assign big      = full[95:47] != '0;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    len_nxt    = len_r;
    last_nxt   = last_r;
    prev_x_nxt = prev_x_r;
    prev_y_nxt = prev_y_r;
    prev_z_nxt = prev_z_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    dz_nxt     = dz_r;
    rad_nxt    = rad_r;
    root_nxt   = root_r;
    srem_nxt   = srem_r;
    step_nxt   = step_r;
    axis_nxt   = axis_r;
    k_nxt      = k_r;
    scale_nxt  = scale_r;
    degen_nxt  = degen_r;
    num_nxt    = num_r;
    t_nxt      = t_r;
    q_nxt      = q_r;
    wlo_nxt    = wlo_r;
    for (int i = 0; i < 3; i++) begin
      pos_nxt[i] = pos_r[i];
      sum_nxt[i] = sum_r[i];
      res_nxt[i] = res_r[i];
    end
    e_val        = {{31{d_sel[32]}}, d_sel};
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = mul_p_r;
    div_divisor  = len_r;
    dm_we        = 1'b0;
    dm_wdata     = {in_dz, in_dy, in_dx};
    pm_we        = 1'b0;
    pm_wdata     = {pos_r[2], pos_r[1], pos_r[0]};

    case (state_r)
      plm_pkg::ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          last_nxt = in_tlast;
          if (count_r < 7'(plm_pkg::MAX_POINTS)) begin
            dm_we      = 1'b1;
            if (count_r == '0) begin
              dm_wdata = '0;
            end
            prev_x_nxt = in_tdata[31:0];
            prev_y_nxt = in_tdata[63:32];
            prev_z_nxt = in_tdata[95:64];
            dx_nxt     = in_dx;
            dy_nxt     = in_dy;
            dz_nxt     = in_dz;
            count_nxt  = count_r + 7'd1;
            if (count_r != '0) begin
              state_nxt = plm_pkg::ST_SQ;
              step_nxt  = '0;
              rad_nxt   = '0;
            end else if (in_tlast) begin
              state_nxt = plm_pkg::ST_DECIDE;
            end
          end else if (in_tlast) begin
            state_nxt = plm_pkg::ST_DECIDE;
          end
        end
      end
      plm_pkg::ST_SQ: begin
        case (step_r)
          6'd0: begin
            mul_a = plm_pkg::mag33(dx_r);
            mul_b = plm_pkg::mag33(dx_r);
          end
          6'd1: begin
            mul_a = plm_pkg::mag33(dy_r);
            mul_b = plm_pkg::mag33(dy_r);
          end
          default: begin
            mul_a = plm_pkg::mag33(dz_r);
            mul_b = plm_pkg::mag33(dz_r);
          end
        endcase
        if (step_r != '0) begin
          rad_nxt = rad_r + {4'h0, mul_p_r};
        end
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd3) begin
          state_nxt = plm_pkg::ST_SQRT;
          step_nxt  = '0;
          srem_nxt  = '0;
          root_nxt  = '0;
        end
      end
      plm_pkg::ST_SQRT: begin
        if (sq_cur >= sq_trial) begin
          srem_nxt = 36'(sq_cur - sq_trial);
          root_nxt = {root_r[32:0], 1'b1};
        end else begin
          srem_nxt = sq_cur[35:0];
          root_nxt = {root_r[32:0], 1'b0};
        end
        rad_nxt  = {rad_r[65:0], 2'b00};
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd33) begin
          len_nxt   = len_r + {6'h0, root_nxt};
          state_nxt = last_r ? plm_pkg::ST_DECIDE : plm_pkg::ST_LOAD;
        end
      end
      plm_pkg::ST_DECIDE: begin
        scale_nxt = 1'b0;
        degen_nxt = count_r < 7'd2;
        num_nxt   = range_max_r;
        if (count_r >= 7'd2) begin
          if (len_r > {8'h0, range_max_r}) begin
            scale_nxt = 1'b1;
          end else if (len_r < {8'h0, range_min_r}) begin
            num_nxt = range_min_r;
            if (len_r == '0) begin
              degen_nxt = 1'b1;
            end else begin
              scale_nxt = 1'b1;
            end
          end
        end
        pm_we    = 1'b1;
        pm_wdata = '0;
        for (int i = 0; i < 3; i++) begin
          pos_nxt[i] = '0;
          sum_nxt[i] = '0;
        end
        axis_nxt = '0;
        if (count_r < 7'd2) begin
          state_nxt = plm_pkg::ST_O_RD;
        end else begin
          k_nxt     = 7'd1;
          state_nxt = plm_pkg::ST_E_RD;
        end
      end
      plm_pkg::ST_E_RD: begin
        state_nxt = plm_pkg::ST_E_AX;
      end
      plm_pkg::ST_E_AX: begin
        if (scale_r) begin
          mul_a     = plm_pkg::mag33(d_sel);
          mul_b     = num_r;
          state_nxt = plm_pkg::ST_E_DIV0;
        end else begin
          pos_nxt[axis_r] = pos_r[axis_r] + e_val;
          sum_nxt[axis_r] = sum_r[axis_r] + pos_r[axis_r] + e_val;
          if (axis_r == 2'd2) begin
            axis_nxt  = '0;
            state_nxt = plm_pkg::ST_E_WR;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end
      end
      plm_pkg::ST_E_DIV0: begin
        div_start = 1'b1;
        state_nxt = plm_pkg::ST_E_DIV;
      end
      plm_pkg::ST_E_DIV: begin
        if (div_done) begin
          e_val           = d_sel[32] ? -q_sat : q_sat;
          pos_nxt[axis_r] = pos_r[axis_r] + e_val;
          sum_nxt[axis_r] = sum_r[axis_r] + pos_r[axis_r] + e_val;
          if (axis_r == 2'd2) begin
            axis_nxt  = '0;
            state_nxt = plm_pkg::ST_E_WR;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = plm_pkg::ST_E_AX;
          end
        end
      end
      plm_pkg::ST_E_WR: begin
        pm_we = 1'b1;
        k_nxt = k_r + 7'd1;
        if (k_r + 7'd1 == count_r) begin
          k_nxt     = '0;
          state_nxt = plm_pkg::ST_O_RD;
        end else begin
          state_nxt = plm_pkg::ST_E_RD;
        end
      end
      plm_pkg::ST_O_RD: begin
        axis_nxt  = '0;
        state_nxt = plm_pkg::ST_O_T;
      end
      plm_pkg::ST_O_T: begin
        t_nxt     = np - sum_r[axis_r];
        state_nxt = plm_pkg::ST_O_DIV0;
      end
      plm_pkg::ST_O_DIV0: begin
        div_start    = 1'b1;
        div_dividend = t_r[63] ? 64'(-t_r) : t_r;
        div_divisor  = {33'h0, count_r};
        state_nxt    = plm_pkg::ST_O_DIV;
      end
      plm_pkg::ST_O_DIV: begin
        if (div_done) begin
          q_nxt     = div_quo;
          state_nxt = plm_pkg::ST_O_ML;
        end
      end
      plm_pkg::ST_O_ML: begin
        mul_a     = q_r[31:0];
        mul_b     = weight_r;
        state_nxt = plm_pkg::ST_O_MH;
      end
      plm_pkg::ST_O_MH: begin
        mul_a     = q_r[63:32];
        mul_b     = weight_r;
        wlo_nxt   = mul_p_r;
        state_nxt = plm_pkg::ST_O_SAT;
      end
      plm_pkg::ST_O_SAT: begin
        if (t_r[63]) begin
          res_nxt[axis_r] = big ? 32'h8000_0000 : -full[47:16];
        end else begin
          res_nxt[axis_r] = big ? 32'h7FFF_FFFF : full[47:16];
        end
        if (axis_r == 2'd2) begin
          state_nxt = plm_pkg::ST_O_SEND;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = plm_pkg::ST_O_T;
        end
      end
      plm_pkg::ST_O_SEND: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          k_nxt = k_r + 7'd1;
          if (k_r + 7'd1 == count_r) begin
            k_nxt     = '0;
            count_nxt = '0;
            len_nxt   = '0;
            last_nxt  = 1'b0;
            state_nxt = plm_pkg::ST_LOAD;
          end else begin
            state_nxt = plm_pkg::ST_O_RD;
          end
        end
      end
      default: begin
        state_nxt = plm_pkg::ST_LOAD;
      end
    endcase
  end

  assign out_tdata = {2'b00, k_r[plm_pkg::PT_AW-1:0], res_r[2], res_r[1], res_r[0]};
  assign out_tlast = (k_r + 7'd1) == count_r;
  assign out_tuser = degen_r;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("Input and output handshakes are both open.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 7'(plm_pkg::MAX_POINTS))
    else $error("Point count exceeds the store depth.");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == plm_pkg::ST_E_DIV || state_r == plm_pkg::ST_O_DIV))
    else $error("Divider finished outside a divide wait state.");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (k_r < count_r))
    else $error("Result word index is beyond the point count.");
`endif

endmodule

>>> tb/testbench.sv
// Self-checking testbench for polyline_length_projection_unit.
// Streams polylines through the block and compares every output word with a built-in
// length-constraint projection predictor. Depends on plm_pkg and the unit only.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic        lst;
  } point_t;

  typedef struct packed {
    logic [31:0] qx;
    logic [31:0] qy;
    logic [31:0] qz;
    logic [5:0]  idx;
    logic        lst;
    logic        dgn;
  } proj_t;

  typedef struct packed {
    point_t      pt;
    logic        chk;
    proj_t       res;
  } row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;
  logic         out_tlast;
  logic         out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;

  polyline_length_projection_unit i_dut (.*);

  logic [31:0]  xs [plm_pkg::MAX_POINTS];
  logic [31:0]  ys [plm_pkg::MAX_POINTS];
  logic [31:0]  zs [plm_pkg::MAX_POINTS];
  int unsigned  npts;
  logic [39:0]  len_acc;
  logic [31:0]  rmin, rmax, wgt;
  proj_t        proj_q [$];
  proj_t        typed_q [$];
  int           errors;
  int           gap_n;
  bit           hold_off;
  bit           sending;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #500ms;
    $display("polyline_length_projection_unit: mismatch");
    $finish;
  end

  function automatic logic [63:0] root_floor(input logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] edge_length(input int k);
    logic signed [63:0] d;
    logic [127:0]       s;
    s = '0;
    d = 64'($signed(xs[k])) - 64'($signed(xs[k-1]));
    s += 128'(d < 0 ? -d : d) * 128'(d < 0 ? -d : d);
    d = 64'($signed(ys[k])) - 64'($signed(ys[k-1]));
    s += 128'(d < 0 ? -d : d) * 128'(d < 0 ? -d : d);
    d = 64'($signed(zs[k])) - 64'($signed(zs[k-1]));
    s += 128'(d < 0 ? -d : d) * 128'(d < 0 ? -d : d);
    return root_floor(s);
  endfunction

  function automatic logic [31:0] weighted(input logic signed [63:0] c);
    logic [63:0]  m;
    logic [127:0] p;
    m = c < 0 ? -c : c;
    p = (128'(m) * 128'(wgt));
    if (p[127:64] != 0) p = {64'd0, 64'hFFFF_FFFF_FFFF_FFFF};
    else p = p >> 16;
    if (c < 0) return (p >= 128'h8000_0000) ? 32'h8000_0000 : 32'(-p[63:0]);
    return (p > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : p[31:0];
  endfunction

  task automatic predict_point(input point_t pt);
    logic signed [63:0] pos [plm_pkg::MAX_POINTS][3];
    logic signed [63:0] tot [3];
    logic signed [63:0] d;
    logic [63:0]        m, q, bound;
    logic signed [63:0] t;
    logic               dgn, scl;
    proj_t              r;
    if (npts < plm_pkg::MAX_POINTS) begin
      xs[npts] = pt.px;
      ys[npts] = pt.py;
      zs[npts] = pt.pz;
      if (npts > 0) len_acc = len_acc + 40'(edge_length(npts));
      npts++;
    end
    if (!pt.lst) return;
    dgn = npts < 2;
    scl = 1'b0;
    bound = '0;
    if (npts >= 2) begin
      if (64'(len_acc) > 64'(rmax)) begin
        scl = 1'b1;
        bound = rmax;
      end else if (64'(len_acc) < 64'(rmin)) begin
        if (len_acc == 0) dgn = 1'b1;
        else begin
          scl = 1'b1;
          bound = rmin;
        end
      end
    end
    for (int a = 0; a < 3; a++) begin
      pos[0][a] = 0;
      tot[a] = 0;
    end
    for (int k = 1; k < npts; k++) begin
      for (int a = 0; a < 3; a++) begin
        case (a)
          0: d = 64'($signed(xs[k])) - 64'($signed(xs[k-1]));
          1: d = 64'($signed(ys[k])) - 64'($signed(ys[k-1]));
          default: d = 64'($signed(zs[k])) - 64'($signed(zs[k-1]));
        endcase
        if (scl) begin
          m = d < 0 ? -d : d;
          q = m * bound / 64'(len_acc);
          if (q > plm_pkg::EDGE_SAT) q = plm_pkg::EDGE_SAT;
          d = d < 0 ? -$signed(q) : $signed(q);
        end
        pos[k][a] = pos[k-1][a] + d;
        tot[a] += pos[k][a];
      end
    end
    for (int k = 0; k < npts; k++) begin
      logic [31:0] o [3];
      for (int a = 0; a < 3; a++) begin
        t = $signed(64'(npts)) * pos[k][a] - tot[a];
        q = (t < 0 ? -t : t) / 64'(npts);
        o[a] = weighted(t < 0 ? -$signed(q) : $signed(q));
      end
      r.qx = o[0];
      r.qy = o[1];
      r.qz = o[2];
      r.idx = 6'(k);
      r.lst = (k + 1 == npts);
      r.dgn = dgn;
      proj_q.insert(proj_q.size(), r);
    end
    npts = 0;
    len_acc = '0;
  endtask

  task automatic send_point(input point_t pt, input logic chk, input proj_t res);
    repeat (gap_n) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {pt.pz, pt.py, pt.px};
    in_tlast  <= pt.lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_point(pt);
    if (chk) begin
      typed_q.insert(typed_q.size(), res);
    end
    gap_n = $urandom_range(0, 6);
    if (gap_n != 0) in_tvalid <= 1'b0;
  endtask

  task automatic stop_input();
    if (gap_n == 0) begin
      in_tvalid <= 1'b0;
      gap_n = 1;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    stop_input();
    while (proj_q.size() != 0) @(posedge clk);
    repeat (14000) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      plm_pkg::CFG_RANGE_MIN: rmin = val;
      plm_pkg::CFG_RANGE_MAX: rmax = val;
      plm_pkg::CFG_WEIGHT:    wgt = val;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rnd_coord(input int span);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return {$urandom_range(0, 1) ? 16'h7FFF : 16'h8000, 16'($urandom())};
      default: return 32'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  task automatic random_lines(input int items, input int span);
    int     left;
    int     n;
    point_t pt;
    proj_t  nil;
    nil = '0;
    left = items;
    while (left > 0) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      if (n > left) n = left;
      for (int i = 0; i < n; i++) begin
        pt.px = rnd_coord(span);
        pt.py = rnd_coord(span);
        pt.pz = rnd_coord(span);
        pt.lst = (i == n - 1);
        send_point(pt, 1'b0, nil);
      end
      left -= n;
    end
  endtask

  initial begin
    proj_t got;
    proj_t exp_r;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = {out_tdata[95:0], out_tdata[101:96], out_tlast, out_tuser};
        got.qx = out_tdata[31:0];
        got.qy = out_tdata[63:32];
        got.qz = out_tdata[95:64];
        if (proj_q.size() == 0) begin
          $error("unexpected word: proj_x %h", got.qx);
          errors++;
        end else begin
          exp_r = proj_q.pop_front();
          if (typed_q.size() != 0 && typed_q[0].idx == got.idx) begin
            if (typed_q[0] != exp_r) begin
              $error("typed row disagrees: expected %h got %h", typed_q[0], exp_r);
              errors++;
            end
            void'(typed_q.pop_front());
          end
          if (got.qx != exp_r.qx) begin
            $error("proj_x expected %h actual %h", exp_r.qx, got.qx);
            errors++;
          end
          if (got.qy != exp_r.qy) begin
            $error("proj_y expected %h actual %h", exp_r.qy, got.qy);
            errors++;
          end
          if (got.qz != exp_r.qz) begin
            $error("proj_z expected %h actual %h", exp_r.qz, got.qz);
            errors++;
          end
          if (got.idx != exp_r.idx) begin
            $error("point_index expected %0d actual %0d", exp_r.idx, got.idx);
            errors++;
          end
          if (got.lst != exp_r.lst) begin
            $error("last_result expected %0b actual %0b", exp_r.lst, got.lst);
            errors++;
          end
          if (got.dgn != exp_r.dgn) begin
            $error("degenerate expected %0b actual %0b", exp_r.dgn, got.dgn);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    row_t   rows [12];
    proj_t  nil;
    point_t pt;
    int     wait_n;
    nil = '0;
    errors = 0;
    gap_n = 0;
    npts = 0;
    len_acc = '0;
    rmin = 32'd0;
    rmax = 32'hFFFF_FFFF;
    wgt = 32'h0001_0000;
    hold_off = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = plm_pkg::CFG_RANGE_MIN;
    cfg_data = '0;
    // Single point: degenerate with a zero result.
    rows[0] = '{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1}, 1'b1,
                '{32'h0, 32'h0, 32'h0, 6'd0, 1'b1, 1'b1}};
    // Two points ten apart: centered at minus and plus five.
    rows[1] = '{'{32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, nil};
    rows[2] = '{'{32'h000A_0000, 32'h0, 32'h0, 1'b1}, 1'b1,
                '{32'h0005_0000, 32'h0, 32'h0, 6'd1, 1'b1, 1'b0}};
    // Extremes of every coordinate.
    rows[3] = '{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0}, 1'b0, nil};
    rows[4] = '{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0}, 1'b0, nil};
    rows[5] = '{'{32'hFFFF_FFFF, 32'h0, 32'h1, 1'b1}, 1'b0, nil};
    // Repeated point: zero length.
    rows[6] = '{'{32'h1234_5678, 32'h1, 32'h2, 1'b0}, 1'b0, nil};
    rows[7] = '{'{32'h1234_5678, 32'h1, 32'h2, 1'b1}, 1'b0, nil};
    rows[8] = '{'{32'h0003_0000, 32'h0004_0000, 32'h0, 1'b0}, 1'b0, nil};
    rows[9] = '{'{32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, nil};
    rows[10] = '{'{32'hFFFD_0000, 32'h0002_0000, 32'h0007_0000, 1'b1}, 1'b0, nil};
    rows[11] = '{'{32'h5555_AAAA, 32'hAAAA_5555, 32'hFFFF_0000, 1'b1}, 1'b1,
                 '{32'h0, 32'h0, 32'h0, 6'd0, 1'b1, 1'b1}};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 12; i++) send_point(rows[i].pt, rows[i].chk, rows[i].res);
    // Overflow of the point store with the last flag past the end.
    for (int i = 0; i < 66; i++) begin
      pt.px = 32'(i * 32'h0001_0000);
      pt.py = $urandom();
      pt.pz = 32'(-i);
      pt.lst = (i == 65);
      send_point(pt, 1'b0, nil);
    end
    random_lines(40, 200000);
    write_reg(plm_pkg::CFG_RANGE_MAX, 32'h0010_0000);
    write_reg(plm_pkg::CFG_RANGE_MIN, 32'h0008_0000);
    write_reg(plm_pkg::CFG_WEIGHT, 32'h0002_8000);
    hold_off = 1'b1;
    random_lines(50, 400000);
    write_reg(plm_pkg::CFG_RANGE_MIN, 32'hFFFF_FFFF);
    write_reg(plm_pkg::CFG_RANGE_MAX, 32'h0);
    write_reg(plm_pkg::CFG_WEIGHT, 32'hFFFF_FFFF);
    random_lines(40, 60000);
    write_reg(plm_pkg::CFG_RANGE_MAX, 32'hFFFF_FFFF);
    write_reg(plm_pkg::CFG_WEIGHT, 32'h0);
    random_lines(30, 60000);
    write_reg(plm_pkg::CFG_RANGE_MIN, $urandom());
    write_reg(plm_pkg::CFG_RANGE_MAX, $urandom());
    write_reg(plm_pkg::CFG_WEIGHT, $urandom_range(0, 32'h0004_0000));
    random_lines(100, 1000000);
    stop_input();
    wait_n = 0;
    while (proj_q.size() != 0 && wait_n < 5000000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (14000) @(posedge clk);
    if (errors == 0 && proj_q.size() == 0) begin
      $display("polyline_length_projection_unit: match");
    end else begin
      $display("polyline_length_projection_unit: mismatch");
    end
    $finish;
  end

endmodule
